// ===== rtl/core/rau_pkg.sv =====
// Package: shared types, constants and operation codes for the rational arithmetic unit.
package rau_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FW = 32;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_CMP = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               less;
    logic               equal;
    logic               greater;
    logic [1:0]         status;
  } out_t;

  // Command to the shared divider and its answer.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/core/rational_arith_unit.sv =====
// Top level: sequencer for rational add, subtract, multiply, divide and compare.
// Errors finish after the operand check and compare after the cross products;
// arithmetic runs three cross products, Euclid's gcd with one division per remainder
// step, then two divisions by the gcd.
// One request at a time: busy falls as out_valid rises, results cannot be stalled.
// Synchronous active-low reset returns to idle with no result pending.
module rational_arith_unit #(
  parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rau_pkg::in_t  in_data,
  output logic          out_valid,
  output rau_pkg::out_t out_data
);
  import rau_pkg::*;

  localparam logic [63:0] LIM = 64'd1 << (VALUE_WIDTH - 1);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_M0   = 13'b0000000000010,
    S_M1   = 13'b0000000000100,
    S_M2   = 13'b0000000001000,
    S_M3   = 13'b0000000010000,
    S_FORM = 13'b0000000100000,
    S_GCD  = 13'b0000001000000,
    S_GW   = 13'b0000010000000,
    S_DN   = 13'b0000100000000,
    S_DNW  = 13'b0001000000000,
    S_DD   = 13'b0010000000000,
    S_DDW  = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  state_t      st_r;
  logic [2:0]  mode_r;
  logic        an_neg_r, bn_neg_r, ad_neg_r, bd_neg_r;
  logic [31:0] an_r, ad_r, bn_r, bd_r;
  logic [63:0] p0_r, p1_r, p2_r;
  logic        num_neg_r;
  logic [63:0] num_r, den_r, ga_r, gb_r, nq_r;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  div_req_t    dreq;
  div_rsp_t    drsp;
  out_t        res_r, res_nxt;
  logic        out_valid_r;
  logic        an_s, bn_s, x_neg, y_neg, rhs_neg;
  logic        bad_c, cmp_lt, cmp_eq, ovf_c;
  logic [63:0] nn_c;
  logic        nneg_c;

  // Sign-extend the low VALUE_WIDTH bits, return sign and magnitude.
  function automatic logic [32:0] to_sm(input logic [31:0] v);
    logic [31:0] x;
    logic        s;
    x = 32'(signed'(v[VALUE_WIDTH-1:0]));
    s = x[31];
    return {s, s ? (32'd0 - x) : x};
  endfunction

  rau_mul u_mul (.clk(clk), .op_a(ma), .op_b(mb), .prod_r(prod));
  rau_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign an_s  = an_neg_r ^ ad_neg_r;
  assign bn_s  = bn_neg_r ^ bd_neg_r;
  assign x_neg = an_s && (p0_r != 64'd0);
  assign y_neg = bn_s && (p1_r != 64'd0);

  assign busy      = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // Select multiplier operands per step.
  always_comb begin
    ma = an_r;
    mb = bd_r;
    unique case (st_r)
      S_M0: if (mode_r == MODE_MUL) mb = bn_r;
      S_M1: begin
        ma = bn_r;
        mb = ad_r;
      end
      S_M2: begin
        ma = ad_r;
        if (mode_r == MODE_DIV) mb = bn_r;
      end
      default: ;
    endcase
  end

  // Flag zero denominators, zero divisor and unknown modes.
  assign bad_c = (ad_r == 32'd0) || (bd_r == 32'd0) || (mode_r > MODE_CMP) ||
                 ((mode_r == MODE_DIV) && (bn_r == 32'd0));

  // Order the two cross products as signed values.
  always_comb begin
    cmp_eq = (x_neg == y_neg) && (p0_r == p1_r);
    if (x_neg != y_neg) cmp_lt = x_neg;
    else if (x_neg)     cmp_lt = (p0_r > p1_r);
    else                cmp_lt = (p0_r < p1_r);
  end

  // Build the exact numerator magnitude and sign.
  always_comb begin
    rhs_neg = (bn_s ^ (mode_r == MODE_SUB)) && (p1_r != 64'd0);
    nn_c    = p0_r;
    nneg_c  = an_s ^ bn_s;
    if (mode_r == MODE_ADD || mode_r == MODE_SUB) begin
      if (x_neg == rhs_neg) begin
        nn_c   = p0_r + p1_r;
        nneg_c = x_neg;
      end else if (p0_r >= p1_r) begin
        nn_c   = p0_r - p1_r;
        nneg_c = x_neg;
      end else begin
        nn_c   = p1_r - p0_r;
        nneg_c = rhs_neg;
      end
    end
  end

  // Check the reduced fraction against the value range.
  assign ovf_c = (drsp.quot > LIM - 64'd1) ||
                 (num_neg_r ? (nq_r > LIM) : (nq_r > LIM - 64'd1));

  // Drive the shared divider: gcd steps, then the two reductions.
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = ga_r;
    dreq.divisor  = gb_r;
    unique case (st_r)
      S_GCD: dreq.start = (gb_r != 64'd0);
      S_DN: begin
        dreq.start    = 1'b1;
        dreq.dividend = num_r;
        dreq.divisor  = ga_r;
      end
      S_DD: begin
        dreq.start    = 1'b1;
        dreq.dividend = den_r;
        dreq.divisor  = ga_r;
      end
      default: ;
    endcase
  end

  // Assemble the result fields.
  always_comb begin
    res_nxt = res_r;
    unique case (st_r)
      S_M0: begin
        res_nxt = '0;
        if (bad_c) res_nxt.status = ST_ZERO;
      end
      S_FORM: if (mode_r == MODE_CMP) begin
        res_nxt.less    = cmp_lt;
        res_nxt.equal   = cmp_eq;
        res_nxt.greater = !cmp_lt && !cmp_eq;
      end
      S_DDW: if (drsp.done) begin
        if (ovf_c) begin
          res_nxt.status = ST_OVF;
        end else begin
          res_nxt.res_num = num_neg_r ? (32'd0 - nq_r[31:0]) : nq_r[31:0];
          res_nxt.res_den = drsp.quot[30:0];
        end
      end
      default: ;
    endcase
  end

  // Advance the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (st_r == S_OUT);
      unique case (st_r)
        S_IDLE: if (start) begin
          {an_neg_r, an_r} <= to_sm(in_data.a_num);
          {ad_neg_r, ad_r} <= to_sm(in_data.a_den);
          {bn_neg_r, bn_r} <= to_sm(in_data.b_num);
          {bd_neg_r, bd_r} <= to_sm(in_data.b_den);
          mode_r <= in_data.mode;
          st_r   <= S_M0;
        end
        S_M0: st_r <= bad_c ? S_OUT : S_M1;
        S_M1: begin
          p0_r <= prod;
          st_r <= S_M2;
        end
        S_M2: begin
          p1_r <= prod;
          st_r <= S_M3;
        end
        S_M3: begin
          p2_r <= prod;
          st_r <= S_FORM;
        end
        S_FORM: begin
          if (mode_r == MODE_CMP) begin
            st_r <= S_OUT;
          end else begin
            num_r     <= nn_c;
            num_neg_r <= nneg_c && (nn_c != 64'd0);
            den_r     <= p2_r;
            ga_r      <= nn_c;
            gb_r      <= p2_r;
            st_r      <= S_GCD;
          end
        end
        S_GCD: st_r <= (gb_r != 64'd0) ? S_GW : S_DN;
        S_GW: if (drsp.done) begin
          ga_r <= gb_r;
          gb_r <= drsp.rem;
          st_r <= S_GCD;
        end
        S_DN:  st_r <= S_DNW;
        S_DNW: if (drsp.done) begin
          nq_r <= drsp.quot;
          st_r <= S_DD;
        end
        S_DD:  st_r <= S_DDW;
        S_DDW: if (drsp.done) st_r <= S_OUT;
        S_OUT: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
    res_r <= res_nxt;
  end
endmodule

// ===== rtl/core/rau_mul.sv =====
// Registered 32x32 unsigned multiplier shared by all cross products.
module rau_mul (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod_r
);
  // Register each product.
  always_ff @(posedge clk) begin
    prod_r <= {32'd0, op_a} * {32'd0, op_b};
  end
endmodule

// ===== rtl/core/rau_div.sv =====
// Radix-2 restoring 64-bit divider, one quotient bit per cycle.
module rau_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t rsp
);
  import rau_pkg::*;

  logic [63:0] quot_r, quot_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;

  assign trial = {rem_r, quot_r[63]} - {1'b0, dvs_r};

  // Load a new request, or shift in one dividend bit and try to subtract.
  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quot_nxt = req.dividend;
      rem_nxt  = 64'd0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[64]) begin
        rem_nxt  = {rem_r[62:0], quot_r[63]};
        quot_nxt = {quot_r[62:0], 1'b0};
      end else begin
        rem_nxt  = trial[63:0];
        quot_nxt = {quot_r[62:0], 1'b1};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;
endmodule

// ===== test/tb_top.sv =====
// Testbench for rational_arith_unit: directed and random requests checked by a scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import rau_pkg::*;

  // Signed-magnitude value at 64 bits.
  typedef struct {
    bit          neg;
    logic [63:0] mag;
  } sgn_mag_t;

  class frac_scoreboard;
    out_t fifo_expected[$];
    int   errors = 0;

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function sgn_mag_t mk(bit neg, logic [63:0] mag);
      sgn_mag_t r;
      r.mag = mag;
      r.neg = neg && (mag != 0);
      return r;
    endfunction

    function sgn_mag_t unpack_field(logic [31:0] v);
      logic [31:0] t;
      t = -v;
      return v[31] ? mk(1'b1, {32'h0, t}) : mk(1'b0, {32'h0, v});
    endfunction

    function sgn_mag_t sum(sgn_mag_t x, sgn_mag_t y);
      if (x.neg == y.neg) return mk(x.neg, x.mag + y.mag);
      if (x.mag >= y.mag) return mk(x.neg, x.mag - y.mag);
      return mk(y.neg, y.mag - x.mag);
    endfunction

    // -1, 0, 1 for x below, equal, above y
    function int order(sgn_mag_t x, sgn_mag_t y);
      if (x.neg != y.neg) return x.neg ? -1 : 1;
      if (x.mag == y.mag) return 0;
      if (x.neg) return (x.mag > y.mag) ? -1 : 1;
      return (x.mag < y.mag) ? -1 : 1;
    endfunction

    function logic [63:0] gcd(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    function out_t fraction_result(in_t req);
      out_t        r;
      sgn_mag_t    an, ad, bn, bd, num, den, rhs;
      logic [63:0] g, nm, dm, lim;
      int          c;
      r = '0;
      an = unpack_field(req.a_num);
      ad = unpack_field(req.a_den);
      bn = unpack_field(req.b_num);
      bd = unpack_field(req.b_den);
      if (ad.mag == 0 || bd.mag == 0 || req.mode > MODE_CMP) begin
        r.status = ST_ZERO;
        return r;
      end
      // move denominator signs onto the numerators
      an = mk(an.neg != ad.neg, an.mag);
      bn = mk(bn.neg != bd.neg, bn.mag);
      if (req.mode == MODE_CMP) begin
        c = order(mk(an.neg, an.mag * bd.mag), mk(bn.neg, bn.mag * ad.mag));
        r.status  = ST_OK;
        r.less    = (c < 0);
        r.equal   = (c == 0);
        r.greater = (c > 0);
        return r;
      end
      case (req.mode)
        MODE_ADD, MODE_SUB: begin
          rhs = mk(bn.neg != (req.mode == MODE_SUB), bn.mag * ad.mag);
          num = sum(mk(an.neg, an.mag * bd.mag), rhs);
          den = mk(1'b0, ad.mag * bd.mag);
        end
        MODE_MUL: begin
          num = mk(an.neg != bn.neg, an.mag * bn.mag);
          den = mk(1'b0, ad.mag * bd.mag);
        end
        default: begin
          if (bn.mag == 0) begin
            r.status = ST_ZERO;
            return r;
          end
          num = mk(an.neg, an.mag * bd.mag);
          den = mk(bn.neg, ad.mag * bn.mag);
        end
      endcase
      num = mk(num.neg != den.neg, num.mag);
      g  = gcd(num.mag, den.mag);
      nm = num.mag / g;
      dm = den.mag / g;
      lim = 64'h8000_0000;
      if (dm > lim - 1 || (num.neg ? nm > lim : nm > lim - 1)) begin
        r.status = ST_OVF;
        return r;
      end
      r.status  = ST_OK;
      r.res_num = num.neg ? 32'(-nm) : nm[31:0];
      r.res_den = dm[30:0];
      return r;
    endfunction

    function void note_request(in_t req);
      fifo_expected.push_back(fraction_result(req));
    endfunction

    task check_result(out_t got);
      out_t want;
      if (fifo_expected.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = fifo_expected.pop_front();
      if (got.res_num !== want.res_num)
        report($sformatf("res_num %0d, want %0d", got.res_num, want.res_num));
      if (got.res_den !== want.res_den)
        report($sformatf("res_den %0d, want %0d", got.res_den, want.res_den));
      if (got.less !== want.less)
        report($sformatf("less %b, want %b", got.less, want.less));
      if (got.equal !== want.equal)
        report($sformatf("equal %b, want %b", got.equal, want.equal));
      if (got.greater !== want.greater)
        report($sformatf("greater %b, want %b", got.greater, want.greater));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask

    function int pending();
      return fifo_expected.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  frac_scoreboard sb = new();
  int             gap_pct;

  rational_arith_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Check every strobed result.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // Issue one request, idling first at the current rate.
  task send_request(in_t req);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) @(negedge clk);
    in_data = req;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(req);
    @(negedge clk);
    start = 1'b0;
  endtask

  function logic [31:0] rand_operand();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return 32'h8000_0000 + $urandom_range(2);
      2:       return 32'h7fff_ffff - $urandom_range(2);
      3:       return 32'(-$urandom_range(300));
      4, 5:    return $urandom_range(300);
      6:       return $urandom_range(65535);
      7:       return 32'(-$urandom_range(65535));
      default: return $urandom_range(20) * 6;
    endcase
  endfunction

  function in_t rand_request();
    in_t r;
    r.mode  = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    r.a_num = rand_operand();
    r.a_den = rand_operand();
    r.b_num = rand_operand();
    r.b_den = rand_operand();
    // mostly nonzero denominators so the arithmetic path gets exercised
    if (r.a_den == 0 && $urandom_range(3) != 0) r.a_den = 1;
    if (r.b_den == 0 && $urandom_range(3) != 0) r.b_den = -1;
    return r;
  endfunction

  task directed(logic [2:0] m, int an, int ad, int bn, int bd);
    in_t r;
    r.mode  = m;
    r.a_num = an;
    r.a_den = ad;
    r.b_num = bn;
    r.b_den = bd;
    send_request(r);
  endtask

  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int waits;
    gap_pct = 18;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners: every mode, zero denominators, zero divisor, bad modes,
    // overflow, zero result, compare outcomes.
    directed(MODE_ADD, 1, 2, 1, 2);
    directed(MODE_SUB, 3, 4, 3, 4);
    directed(MODE_MUL, -6, 4, 2, -3);
    directed(MODE_DIV, 1, 3, -2, 9);
    directed(MODE_DIV, 5, 7, 0, 3);
    directed(MODE_ADD, 1, 0, 1, 1);
    directed(MODE_CMP, 1, 1, 1, 0);
    directed(MODE_CMP, 1, 3, 2, 6);
    directed(MODE_CMP, -1, 3, 1, 3);
    directed(MODE_CMP, 5, -3, -2, 1);
    directed(3'd5, 1, 1, 1, 1);
    directed(3'd6, 1, 1, 1, 1);
    directed(3'd7, 0, 0, 0, 0);
    directed(MODE_MUL, 32'h8000_0000, -1, 1, 1);
    directed(MODE_MUL, 32'h8000_0000, 1, 1, 1);
    directed(MODE_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    directed(MODE_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    directed(MODE_MUL, 32'h7fff_ffff, 32'h8000_0000, -1, 32'h7fff_ffff);
    directed(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    directed(MODE_ADD, 1, 32'h7fff_ffff, 1, 32'h7fff_fffe);
    directed(MODE_SUB, 0, -5, 0, 7);
    directed(MODE_CMP, 32'h8000_0000, 1, 32'h7fff_ffff, 1);

    // Wait until no expected result is pending, or until the wait limit runs out.
    waits = 0;
    while (sb.pending() != 0 && waits < 100_000) begin
      @(posedge clk);
      waits++;
    end
    repeat (10) @(posedge clk);

    // Random phases: light idling, heavy idling, none.
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 18 : (phase == 1) ? 83 : 0;
      for (int n = 0; n < 430; n++) send_request(rand_request());
    end

    waits = 0;
    while (sb.pending() != 0 && waits < 100_000) begin
      @(posedge clk);
      waits++;
    end
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== rational_arith_unit.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_mul.sv
rtl/core/rau_div.sv
rtl/core/rational_arith_unit.sv
test/tb_top.sv
